FILE: src/dqr_pkg.sv
package dqr_pkg;

    // Width of every operand port and of the quotient and remainder ports.
    localparam int FIELD_WIDTH = 64;

    // Default operand width used inside the datapath.
    localparam int DATA_WIDTH_DEF = 64;

    // Entries in the queue between the front end and the divider pipeline (power of two).
    localparam int QUEUE_DEPTH_DEF = 4;

    // Mode codes carried on the command input.
    typedef enum logic {
        CMD_UNSIGNED_QR = 1'b0,
        CMD_SIGNED_REM  = 1'b1
    } dqr_cmd_t;

    // Per-item classification that travels alongside the operand magnitudes.
    typedef struct packed {
        logic rem_mode;   // signed remainder requested, quotient dropped unless divisor is zero
        logic neg;        // dividend was negative, remainder gets negated at the end
        logic zero;       // divisor was zero
    } dqr_flags_t;

    localparam int FLAGS_BITS = $bits(dqr_flags_t);

endpackage

FILE: src/divide_64bit_quotient_remainder_core.sv
// Pipelined integer divider, one quotient and remainder per beat.
// Input channel (s_valid/s_ready): s_cmd selects unsigned quotient and
// remainder or signed remainder with the dividend's sign; s_dividend and
// s_divisor carry the operands, of which the low DATA_WIDTH bits are used.
// Result channel (m_valid/m_ready): m_quotient, m_remainder, m_div_by_zero.
// A zero divisor sets m_div_by_zero, returns an all-ones quotient and gives
// the dividend back as the remainder. In signed mode the quotient reads zero
// unless the divisor was zero. An accepted input beat passes through the input
// queue, the one-bit restoring stages and the output register before m_valid.
// Throughput is one beat per cycle while the receiver takes results: the
// one-bit-per-stage pipeline advances whenever the output register is empty
// or being read.
// When the receiver stalls, the pipeline freezes behind the output register
// and the input queue (QUEUE_DEPTH entries) keeps taking beats until it fills.
// Reset clears the queue and all valid flags; no results are pending after it.
module divide_64bit_quotient_remainder_core #(
    parameter int DATA_WIDTH  = dqr_pkg::DATA_WIDTH_DEF,
    parameter int QUEUE_DEPTH = dqr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_cmd,
    input  logic [dqr_pkg::FIELD_WIDTH-1:0]  s_dividend,
    input  logic [dqr_pkg::FIELD_WIDTH-1:0]  s_divisor,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [dqr_pkg::FIELD_WIDTH-1:0]  m_quotient,
    output logic [dqr_pkg::FIELD_WIDTH-1:0]  m_remainder,
    output logic                             m_div_by_zero
);

    localparam int ENTRY_BITS = 2 * DATA_WIDTH + dqr_pkg::FLAGS_BITS;

    logic                    q_full;
    logic                    q_push;
    logic                    q_pop;
    logic                    q_not_empty;
    logic [DATA_WIDTH-1:0]   push_mag_dividend;
    logic [DATA_WIDTH-1:0]   push_mag_divisor;
    dqr_pkg::dqr_flags_t     push_flags;
    logic [ENTRY_BITS-1:0]   push_entry;
    logic [ENTRY_BITS-1:0]   head_entry;
    logic [DATA_WIDTH-1:0]   head_mag_dividend;
    logic [DATA_WIDTH-1:0]   head_mag_divisor;
    dqr_pkg::dqr_flags_t     head_flags;

    // Front end: takes the beat and reduces it to magnitudes and flags.
    dqr_front #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_dividend     (s_dividend),
        .s_divisor      (s_divisor),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_mag_dividend (push_mag_dividend),
        .q_mag_divisor  (push_mag_divisor),
        .q_flags        (push_flags)
    );

    assign push_entry = {push_flags, push_mag_divisor, push_mag_dividend};
    assign {head_flags, head_mag_divisor, head_mag_dividend} = head_entry;

    // Short queue decoupling the front end from the divider pipeline.
    dqr_queue #(
        .DATA_BITS (ENTRY_BITS),
        .DEPTH     (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_entry),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_data (head_entry)
    );

    // Back end: restoring divider pipeline and output register.
    dqr_back #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (q_not_empty),
        .in_pop          (q_pop),
        .in_mag_dividend (head_mag_dividend),
        .in_mag_divisor  (head_mag_divisor),
        .in_flags        (head_flags),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_quotient      (m_quotient),
        .m_remainder     (m_remainder),
        .m_div_by_zero   (m_div_by_zero)
    );

endmodule

FILE: src/dqr_front.sv
module dqr_front #(
    parameter int DATA_WIDTH = dqr_pkg::DATA_WIDTH_DEF
) (
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_cmd,
    input  logic [dqr_pkg::FIELD_WIDTH-1:0]  s_dividend,
    input  logic [dqr_pkg::FIELD_WIDTH-1:0]  s_divisor,
    input  logic                             q_full,
    output logic                             q_push,
    output logic [DATA_WIDTH-1:0]            q_mag_dividend,
    output logic [DATA_WIDTH-1:0]            q_mag_divisor,
    output dqr_pkg::dqr_flags_t              q_flags
);

    logic [DATA_WIDTH-1:0] dvd;
    logic [DATA_WIDTH-1:0] dvs;
    logic                  signed_mode;
    logic                  dvs_neg;

    // A beat is taken whenever the queue has room.
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Only the low DATA_WIDTH bits of each operand take part.
    assign dvd         = s_dividend[DATA_WIDTH-1:0];
    assign dvs         = s_divisor[DATA_WIDTH-1:0];
    assign signed_mode = (dqr_pkg::dqr_cmd_t'(s_cmd) == dqr_pkg::CMD_SIGNED_REM);
    assign dvs_neg     = signed_mode && dvs[DATA_WIDTH-1];

    // Classify the item and reduce signed operands to their magnitudes.
    always_comb begin
        q_flags.rem_mode = signed_mode;
        q_flags.neg      = signed_mode && dvd[DATA_WIDTH-1];
        q_flags.zero     = (dvs == '0);
        q_mag_dividend   = q_flags.neg ? (DATA_WIDTH'(0) - dvd) : dvd;
        q_mag_divisor    = dvs_neg ? (DATA_WIDTH'(0) - dvs) : dvs;
    end

endmodule

FILE: src/dqr_queue.sv
module dqr_queue #(
    parameter int DATA_BITS = 8,
    parameter int DEPTH     = dqr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  logic [DATA_BITS-1:0] push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output logic [DATA_BITS-1:0] head_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] entry_reg [DEPTH];
    logic [PW-1:0]        wr_ptr_reg;
    logic [PW-1:0]        wr_ptr_next;
    logic [PW-1:0]        rd_ptr_reg;
    logic [PW-1:0]        rd_ptr_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_data = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/dqr_back.sv
module dqr_back #(
    parameter int DATA_WIDTH = dqr_pkg::DATA_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_pop,
    input  logic [DATA_WIDTH-1:0]            in_mag_dividend,
    input  logic [DATA_WIDTH-1:0]            in_mag_divisor,
    input  dqr_pkg::dqr_flags_t              in_flags,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [dqr_pkg::FIELD_WIDTH-1:0]  m_quotient,
    output logic [dqr_pkg::FIELD_WIDTH-1:0]  m_remainder,
    output logic                             m_div_by_zero
);

    localparam int W = DATA_WIDTH;

    // Per-stage state: partial remainder, dividend bits shifting out on top with
    // quotient bits shifting in at the bottom, the divisor, and the item flags.
    logic [W-1:0]        rem_reg   [W];
    logic [W-1:0]        qd_reg    [W];
    logic [W-1:0]        dvs_reg   [W];
    dqr_pkg::dqr_flags_t flags_reg [W];
    logic                vld_reg   [W];

    logic [W-1:0]        rem_in    [W];
    logic [W-1:0]        qd_in     [W];
    logic [W-1:0]        dvs_in    [W];
    dqr_pkg::dqr_flags_t flags_in  [W];
    logic                vld_in    [W];

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [W-1:0]        out_quo_reg;
    logic [W-1:0]        out_quo_next;
    logic [W-1:0]        out_rem_reg;
    logic [W-1:0]        out_rem_next;
    logic                out_zero_reg;
    logic                advance;

    // The whole pipeline moves together unless a finished beat is held at the output.
    assign advance = !out_valid_reg || m_ready;
    assign in_pop  = advance && in_valid;

    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W:0]   trial;
        logic [W:0]   diff;
        logic         fits;
        logic [W-1:0] rem_next;
        logic [W-1:0] qd_next;

        // Stage inputs come from the queue head or the stage before.
        if (k == 0) begin : g_first
            assign rem_in[k]   = '0;
            assign qd_in[k]    = in_mag_dividend;
            assign dvs_in[k]   = in_mag_divisor;
            assign flags_in[k] = in_flags;
            assign vld_in[k]   = in_valid;
        end else begin : g_next
            assign rem_in[k]   = rem_reg[k-1];
            assign qd_in[k]    = qd_reg[k-1];
            assign dvs_in[k]   = dvs_reg[k-1];
            assign flags_in[k] = flags_reg[k-1];
            assign vld_in[k]   = vld_reg[k-1];
        end

        // One restoring step: bring down a dividend bit, subtract if it fits.
        always_comb begin
            trial    = {rem_in[k], qd_in[k][W-1]};
            diff     = trial - {1'b0, dvs_in[k]};
            fits     = !diff[W];
            rem_next = fits ? diff[W-1:0] : trial[W-1:0];
            qd_next  = {qd_in[k][W-2:0], fits};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (advance) begin
                vld_reg[k] <= vld_in[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                rem_reg[k]   <= rem_next;
                qd_reg[k]    <= qd_next;
                dvs_reg[k]   <= dvs_in[k];
                flags_reg[k] <= flags_in[k];
            end
        end
    end

    // Final fix-up: restore the dividend's sign on the remainder, and drop the
    // quotient in signed-remainder mode unless the divisor was zero.
    always_comb begin
        out_valid_next = advance ? vld_reg[W-1] : out_valid_reg;
        out_rem_next   = flags_reg[W-1].neg ? (W'(0) - rem_reg[W-1]) : rem_reg[W-1];
        out_quo_next   = (flags_reg[W-1].rem_mode && !flags_reg[W-1].zero) ?
                         '0 : qd_reg[W-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_quo_reg  <= out_quo_next;
            out_rem_reg  <= out_rem_next;
            out_zero_reg <= flags_reg[W-1].zero;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_quotient    = dqr_pkg::FIELD_WIDTH'(out_quo_reg);
    assign m_remainder   = dqr_pkg::FIELD_WIDTH'(out_rem_reg);
    assign m_div_by_zero = out_zero_reg;

endmodule

FILE: src/dqr_checker.sv
module dqr_checker #(
    parameter int DATA_WIDTH = dqr_pkg::DATA_WIDTH_DEF
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [dqr_pkg::FIELD_WIDTH-1:0]  m_quotient,
    input logic [dqr_pkg::FIELD_WIDTH-1:0]  m_remainder,
    input logic                             m_div_by_zero
);

    // A held result beat keeps its contents while the receiver stalls.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_quotient) && $stable(m_remainder)
            && $stable(m_div_by_zero))
        else $error("result beat changed while stalled");

    // A zero divisor always reports an all-ones quotient.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_div_by_zero |-> m_quotient[DATA_WIDTH-1:0] == '1)
        else $error("zero divisor without all-ones quotient");

    // Results never carry bits above the datapath width.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_quotient >> DATA_WIDTH) == '0 && (m_remainder >> DATA_WIDTH) == '0)
        else $error("result bits above the datapath width");

    // Nothing is pending right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // The input side takes beats as soon as reset is released.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> s_ready)
        else $error("input not ready after reset");

endmodule

bind divide_64bit_quotient_remainder_core dqr_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_dqr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_quotient    (m_quotient),
    .m_remainder   (m_remainder),
    .m_div_by_zero (m_div_by_zero)
);
